// ===== rtl/core/dma_descriptor_table_builder_assert.svh =====
// ----------------------------------------------------------------------------
// dma_descriptor_table_builder_assert
// Assertion macros used by the checker file of the descriptor table builder.
// ----------------------------------------------------------------------------
`ifndef DMA_DESCRIPTOR_TABLE_BUILDER_ASSERT_SVH
`define DMA_DESCRIPTOR_TABLE_BUILDER_ASSERT_SVH

// same-cycle implication
`define DTB_ASSERT_IMPLY(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
      else $error("dtb assertion failed");

// next-cycle implication
`define DTB_ASSERT_NEXT(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
      else $error("dtb assertion failed");

`endif

// ===== rtl/core/dtb_pkg.sv =====
// ----------------------------------------------------------------------------
// dtb_pkg
// Shared types and constants of the descriptor table builder.
// ----------------------------------------------------------------------------
`default_nettype none

package dtb_pkg;

   localparam int MAX_ENTRIES_DEFAULT = 8;
   localparam int RESULT_CAP          = 3;   // 128 KiB spans at most three windows
   localparam int QUEUE_DEPTH         = 2;

   localparam logic [8:0]  MAX_SECTORS  = 9'd256;
   localparam logic [16:0] WINDOW_BYTES = 17'h10000;
   localparam logic [15:0] WINDOW_MASK  = 16'hFFFF;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_INVALID   = 2'd1,
      STATUS_TOO_LARGE = 2'd2
   } status_type;

   // classified request, as queued between front and back
   typedef struct packed {
      logic [31:0] addr;
      logic [17:0] bytes;
      logic        invalid;
   } job_type;

endpackage

`default_nettype wire

// ===== rtl/core/dtb_front.sv =====
// ----------------------------------------------------------------------------
// dtb_front
// Validates a request and turns the sector count into a byte count.
// ----------------------------------------------------------------------------
`default_nettype none

module dtb_front (
   input  wire logic [31:0]     req_buffer_addr,
   input  wire logic [8:0]      req_sectors,
   output dtb_pkg::job_type     job
);

   always_comb begin
      job.addr    = req_buffer_addr;
      job.bytes   = {req_sectors, 9'd0};
      job.invalid = (req_buffer_addr == 32'd0) || (req_sectors == 9'd0) ||
                    (req_sectors > dtb_pkg::MAX_SECTORS);
   end

endmodule

`default_nettype wire

// ===== rtl/core/dtb_queue.sv =====
// ----------------------------------------------------------------------------
// dtb_queue
// Short job queue between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module dtb_queue (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire dtb_pkg::job_type wdata,
   input  wire logic             pop,
   output dtb_pkg::job_type      rdata,
   output logic                  empty,
   output logic                  full
);

   localparam int DEPTH = dtb_pkg::QUEUE_DEPTH;
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   dtb_pkg::job_type slot_ff [DEPTH];
   logic [PTR_W-1:0] wptr_ff, rptr_ff;
   logic [CNT_W-1:0] count_ff;

   function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
      if (p == PTR_W'(DEPTH - 1)) begin
         return '0;
      end
      return p + PTR_W'(1);
   endfunction

   assign empty = (count_ff == '0);
   assign full  = (count_ff == CNT_W'(DEPTH));
   assign rdata = slot_ff[rptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         if (push) begin
            wptr_ff <= bump(wptr_ff);
         end
         if (pop) begin
            rptr_ff <= bump(rptr_ff);
         end
         if (push && !pop) begin
            count_ff <= count_ff + CNT_W'(1);
         end else if (pop && !push) begin
            count_ff <= count_ff - CNT_W'(1);
         end
      end
      if (push) begin
         slot_ff[wptr_ff] <= wdata;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/dtb_back.sv =====
// ----------------------------------------------------------------------------
// dtb_back
// Splits one queued job into descriptor beats, one per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module dtb_back #(
   parameter int MAX_ENTRIES = dtb_pkg::MAX_ENTRIES_DEFAULT
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire dtb_pkg::job_type job,
   input  wire logic             q_empty,
   output logic                  pop,
   output logic                  rsp_valid,
   output logic [31:0]           rsp_entry_addr,
   output logic [15:0]           rsp_entry_bytes,
   output logic                  rsp_end_of_table,
   output logic                  rsp_last,
   output logic [1:0]            rsp_status
);

   localparam int ENTRY_LIMIT = (MAX_ENTRIES < dtb_pkg::RESULT_CAP) ?
                                MAX_ENTRIES : dtb_pkg::RESULT_CAP;
   localparam int CNT_W = $clog2(ENTRY_LIMIT + 1);

   logic              active_ff;
   logic              invalid_ff;
   logic [31:0]       addr_ff;
   logic [17:0]       rem_ff;
   logic [CNT_W-1:0]  cnt_ff;

   logic                rsp_valid_ff;
   logic [31:0]         rsp_addr_ff;
   logic [15:0]         rsp_bytes_ff;
   logic                rsp_eot_ff;
   logic                rsp_last_ff;
   dtb_pkg::status_type rsp_status_ff;

   logic [16:0] room;
   logic [17:0] chunk;
   logic [17:0] rem_left;
   logic        at_limit;
   logic        fin;

   always_comb begin
      room     = dtb_pkg::WINDOW_BYTES - {1'b0, addr_ff[15:0] & dtb_pkg::WINDOW_MASK};
      chunk    = (rem_ff < {1'b0, room}) ? rem_ff : {1'b0, room};
      rem_left = rem_ff - chunk;
      at_limit = (cnt_ff == CNT_W'(ENTRY_LIMIT - 1));
      fin      = active_ff && (invalid_ff || (rem_left == 18'd0) || at_limit);
      pop      = !q_empty && (!active_ff || fin);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= active_ff;
         if (pop) begin
            active_ff <= 1'b1;
         end else if (fin) begin
            active_ff <= 1'b0;
         end
      end

      if (pop) begin
         addr_ff    <= job.addr;
         rem_ff     <= job.bytes;
         invalid_ff <= job.invalid;
         cnt_ff     <= '0;
      end else if (active_ff) begin
         addr_ff <= addr_ff + {14'd0, chunk};
         rem_ff  <= rem_left;
         cnt_ff  <= cnt_ff + CNT_W'(1);
      end

      if (active_ff) begin
         if (invalid_ff) begin
            rsp_addr_ff   <= 32'd0;
            rsp_bytes_ff  <= 16'd0;
            rsp_eot_ff    <= 1'b0;
            rsp_last_ff   <= 1'b1;
            rsp_status_ff <= dtb_pkg::STATUS_INVALID;
         end else begin
            rsp_addr_ff   <= addr_ff;
            rsp_bytes_ff  <= chunk[15:0];  // 65536 wraps to 0
            rsp_eot_ff    <= (rem_left == 18'd0);
            rsp_last_ff   <= fin;
            rsp_status_ff <= ((rem_left != 18'd0) && at_limit) ?
                             dtb_pkg::STATUS_TOO_LARGE : dtb_pkg::STATUS_OK;
         end
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_entry_addr   = rsp_addr_ff;
   assign rsp_entry_bytes  = rsp_bytes_ff;
   assign rsp_end_of_table = rsp_eot_ff;
   assign rsp_last         = rsp_last_ff;
   assign rsp_status       = rsp_status_ff;

endmodule

`default_nettype wire

// ===== rtl/core/dma_descriptor_table_builder.sv =====
// ----------------------------------------------------------------------------
// dma_descriptor_table_builder
// Builds bus-master descriptor entries from a buffer address and sector count.
// ----------------------------------------------------------------------------
// Request channel: drive req_buffer_addr / req_sectors with start high; the
// beat is taken at a clock edge where busy is low. busy is high only while
// the two-entry job queue is full.
// Result channel: each descriptor beat is shown for one cycle with rsp_valid
// high. A request gives 1 to 3 beats on consecutive cycles; rsp_last marks
// the final beat. Invalid requests (zero address, zero or more than 256
// sectors) give a single beat with status invalid. If the entry limit is
// reached with bytes left, the final beat reports too large and carries no
// end-of-table flag.
// A taken request is queued, loaded into the back end, then registered out.
// Throughput: one beat per cycle while the back end has a job; each request's
// beats (at most 3) come from the back end's chunk loop, which handles one
// 64 KiB window per cycle and moves to the next queued job without a gap.
// Reset clears the queue and the back end; no beat is emitted during it.
// The receiver cannot stall: beats are never held.
// ----------------------------------------------------------------------------
`default_nettype none

module dma_descriptor_table_builder #(
   parameter int MAX_ENTRIES = dtb_pkg::MAX_ENTRIES_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [31:0] req_buffer_addr,
   input  wire logic [8:0]  req_sectors,
   output logic             rsp_valid,
   output logic [31:0]      rsp_entry_addr,
   output logic [15:0]      rsp_entry_bytes,
   output logic             rsp_end_of_table,
   output logic             rsp_last,
   output logic [1:0]       rsp_status
);

   dtb_pkg::job_type front_job;
   dtb_pkg::job_type queue_job;
   logic             q_empty;
   logic             q_full;
   logic             q_pop;
   logic             accept;

   assign busy   = q_full;
   assign accept = start && !q_full;

   // front: classify and size the request
   dtb_front u_front (
      .req_buffer_addr (req_buffer_addr),
      .req_sectors     (req_sectors),
      .job             (front_job)
   );

   // decoupling queue
   dtb_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (accept),
      .wdata (front_job),
      .pop   (q_pop),
      .rdata (queue_job),
      .empty (q_empty),
      .full  (q_full)
   );

   // back: window splitting and result beats
   dtb_back #(
      .MAX_ENTRIES (MAX_ENTRIES)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .job              (queue_job),
      .q_empty          (q_empty),
      .pop              (q_pop),
      .rsp_valid        (rsp_valid),
      .rsp_entry_addr   (rsp_entry_addr),
      .rsp_entry_bytes  (rsp_entry_bytes),
      .rsp_end_of_table (rsp_end_of_table),
      .rsp_last         (rsp_last),
      .rsp_status       (rsp_status)
   );

endmodule

`default_nettype wire

// ===== rtl/core/dtb_checker.sv =====
// ----------------------------------------------------------------------------
// dtb_checker
// Port-level checks of the descriptor table builder, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
`include "dma_descriptor_table_builder_assert.svh"

module dtb_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        busy,
   input wire logic        rsp_valid,
   input wire logic [31:0] rsp_entry_addr,
   input wire logic [15:0] rsp_entry_bytes,
   input wire logic        rsp_end_of_table,
   input wire logic        rsp_last,
   input wire logic [1:0]  rsp_status
);

   logic inv_beat, big_beat, eot_beat, mid_beat;
   logic inv_empty, eot_good, big_end, run_next;

   assign inv_beat = rsp_valid && (rsp_status == dtb_pkg::STATUS_INVALID);
   assign big_beat = rsp_valid && (rsp_status == dtb_pkg::STATUS_TOO_LARGE);
   assign eot_beat = rsp_valid && rsp_end_of_table;
   assign mid_beat = rsp_valid && !rsp_last;

   assign inv_empty = rsp_last && !rsp_end_of_table && (rsp_entry_addr == 32'd0) &&
                      (rsp_entry_bytes == 16'd0);
   assign eot_good  = rsp_last && (rsp_status == dtb_pkg::STATUS_OK);
   assign big_end   = rsp_last && !rsp_end_of_table;
   assign run_next  = rsp_valid && (rsp_entry_addr[15:0] == 16'd0);

   // invalid beat is a lone, empty beat
   `DTB_ASSERT_IMPLY(a_invalid_beat, clock, reset, inv_beat, inv_empty)
   // end of table only on a good final beat
   `DTB_ASSERT_IMPLY(a_eot_final, clock, reset, eot_beat, eot_good)
   // overflow ends the run without end of table
   `DTB_ASSERT_IMPLY(a_too_large, clock, reset, big_beat, big_end)
   // a run continues on the next cycle, starting at a window boundary
   `DTB_ASSERT_NEXT(a_run_contig, clock, reset, mid_beat, run_next)
   // queue full means the back end is mid-job, so a beat follows
   `DTB_ASSERT_NEXT(a_busy_drains, clock, reset, busy, rsp_valid)

endmodule

bind dma_descriptor_table_builder dtb_checker u_dtb_checker (.*);

`default_nettype wire
